// ----- rtl/odo_pkg.sv -----
`default_nettype none
package odo_pkg;

	localparam int unsigned COUNT_W = 16;
	localparam int unsigned CFG_IDX_W = 2;
	localparam int unsigned CFG_DATA_W = 24;

	localparam logic [CFG_IDX_W-1:0] CFG_METERS_PER_TICK = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_RIGHT_RATIO = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_LEFT_RATIO = 2'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_INV_WHEEL_BASE = 2'd3;

	localparam logic REQ_UPDATE = 1'b0;
	localparam logic REQ_RESET = 1'b1;

	// angles in Q24 radians, cordic values in Q30
	localparam logic [33:0] PI_Q24 = 34'd52707179;
	localparam logic [33:0] HALF_PI_Q24 = 34'd26353589;
	localparam logic [33:0] TWO_PI_Q24 = 34'd105414357;
	// 21 turns, lifts any 32-bit heading above zero
	localparam logic [33:0] TURNS_OFFSET = 34'd2213701497;
	localparam logic signed [31:0] GAIN_Q30 = 32'sd652032874;

	typedef struct packed {
		logic req_type;
		logic [COUNT_W-1:0] right_count;
		logic [COUNT_W-1:0] left_count;
	} in_word_t;

	typedef struct packed {
		logic signed [31:0] pos_x;
		logic signed [31:0] pos_y;
		logic signed [31:0] heading;
		logic signed [31:0] step_distance;
		logic signed [31:0] right_travel;
		logic signed [31:0] left_travel;
	} out_word_t;

	typedef struct packed {
		logic [23:0] meters_per_tick;
		logic [17:0] right_ratio;
		logic [17:0] left_ratio;
		logic [23:0] inv_wheel_base;
	} cfg_t;

	function automatic logic [23:0] atan_q24(input logic [4:0] idx);
		logic [23:0] v;
		case (idx)
			5'd0: v = 24'd13176795;
			5'd1: v = 24'd7778716;
			5'd2: v = 24'd4110060;
			5'd3: v = 24'd2086331;
			5'd4: v = 24'd1047214;
			5'd5: v = 24'd524117;
			5'd6: v = 24'd262123;
			5'd7: v = 24'd131069;
			5'd8: v = 24'd65536;
			5'd9: v = 24'd32768;
			5'd10: v = 24'd16384;
			5'd11: v = 24'd8192;
			5'd12: v = 24'd4096;
			5'd13: v = 24'd2048;
			5'd14: v = 24'd1024;
			5'd15: v = 24'd512;
			5'd16: v = 24'd256;
			5'd17: v = 24'd128;
			5'd18: v = 24'd64;
			5'd19: v = 24'd32;
			5'd20: v = 24'd16;
			5'd21: v = 24'd8;
			5'd22: v = 24'd4;
			5'd23: v = 24'd2;
			5'd24: v = 24'd1;
			default: v = 24'd0;
		endcase
		return v;
	endfunction

endpackage
`default_nettype wire

// ----- rtl/odo_front.sv -----
`default_nettype none
module odo_front #(
	parameter int unsigned ENC_W = 16
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic in_valid,
	output logic in_stall,
	input wire odo_pkg::in_word_t in_word,
	output logic q_valid,
	input wire logic q_pop,
	output logic q_req,
	output logic [ENC_W-1:0] q_dr,
	output logic [ENC_W-1:0] q_dl
);

	logic [ENC_W-1:0] right_prev_q, left_prev_q;
	logic [ENC_W-1:0] rc, lc;
	logic ent_req_q [2];
	logic [ENC_W-1:0] ent_dr_q [2];
	logic [ENC_W-1:0] ent_dl_q [2];
	logic wr_ptr_q, rd_ptr_q;
	logic [1:0] cnt_q;
	logic push, pop;

	assign rc = ENC_W'(in_word.right_count);
	assign lc = ENC_W'(in_word.left_count);
	assign in_stall = (cnt_q == 2'd2);
	assign push = in_valid && !in_stall;
	assign pop = q_pop && q_valid;
	assign q_valid = (cnt_q != 2'd0);
	assign q_req = ent_req_q[rd_ptr_q];
	assign q_dr = ent_dr_q[rd_ptr_q];
	assign q_dl = ent_dl_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			right_prev_q <= '0;
			left_prev_q <= '0;
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) begin
				right_prev_q <= rc;
				left_prev_q <= lc;
				wr_ptr_q <= !wr_ptr_q;
			end
			if (pop)
				rd_ptr_q <= !rd_ptr_q;
			if (push && !pop)
				cnt_q <= cnt_q + 2'd1;
			else if (pop && !push)
				cnt_q <= cnt_q - 2'd1;
		end
	end

	// deltas wrap at the counter width and read as signed
	always_ff @(posedge clk) begin
		if (push) begin
			ent_req_q[wr_ptr_q] <= in_word.req_type;
			ent_dr_q[wr_ptr_q] <= rc - right_prev_q;
			ent_dl_q[wr_ptr_q] <= lc - left_prev_q;
		end
	end

endmodule
`default_nettype wire

// ----- rtl/odo_back.sv -----
`default_nettype none
module odo_back #(
	parameter int unsigned ENC_W = 16,
	parameter int unsigned ITER = 24
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire odo_pkg::cfg_t cfg,
	input wire logic q_valid,
	output logic q_pop,
	input wire logic q_req,
	input wire logic [ENC_W-1:0] q_dr,
	input wire logic [ENC_W-1:0] q_dl,
	output logic out_valid,
	input wire logic out_stall,
	output odo_pkg::out_word_t out_word
);

	localparam int unsigned NSTEP = (ITER > 32) ? 32 : ITER;
	localparam logic [5:0] LAST_STEP = 6'(NSTEP - 1);

	typedef enum logic [3:0] {
		S_IDLE, S_MUL1, S_MUL2, S_HEAD, S_RED, S_FOLD, S_CORD, S_POS, S_ACC, S_OUT
	} state_t;

	state_t state_q;
	logic signed [ENC_W-1:0] dr_q, dl_q;
	logic [55:0] tr_q, tl_q;
	logic [31:0] rd_q, ld_q;
	logic signed [31:0] mean_q;
	logic [33:0] red_q;
	logic [2:0] k_q;
	logic signed [27:0] r_q;
	logic signed [31:0] x_q, y_q;
	logic neg_q;
	logic [5:0] it_q;
	logic signed [31:0] px_q, py_q;
	logic [31:0] x_acc_q, y_acc_q, heading_acc_q, right_acc_q, left_acc_q;
	logic out_valid_q;
	odo_pkg::out_word_t out_word_q;

	logic [55:0] dr_ext, dl_ext, p_r, p_l;
	logic signed [32:0] sum, diff;
	logic [39:0] hp;
	logic [31:0] heading_new;
	logic [33:0] red_sub;
	logic signed [27:0] r0, r1;
	logic signed [31:0] dx, dy, cosv, sinv;
	logic signed [27:0] atn;
	logic signed [63:0] prod_x, prod_y;
	logic load_out;

	assign dr_ext = 56'(dr_q);
	assign dl_ext = 56'(dl_q);
	assign p_r = tr_q * {38'd0, cfg.right_ratio};
	assign p_l = tl_q * {38'd0, cfg.left_ratio};
	assign sum = 33'($signed(rd_q)) + 33'($signed(ld_q));
	assign diff = 33'($signed(rd_q)) - 33'($signed(ld_q));
	assign hp = 40'(diff) * {16'd0, cfg.inv_wheel_base};
	assign heading_new = heading_acc_q + hp[39:8];
	assign red_sub = odo_pkg::TWO_PI_Q24 << k_q;
	assign r0 = (red_q > odo_pkg::PI_Q24) ? $signed(red_q[27:0] - odo_pkg::TWO_PI_Q24[27:0])
		: $signed(red_q[27:0]);
	assign dx = y_q >>> it_q[4:0];
	assign dy = x_q >>> it_q[4:0];
	assign atn = $signed({4'd0, odo_pkg::atan_q24(it_q[4:0])});
	assign cosv = neg_q ? -x_q : x_q;
	assign sinv = neg_q ? -y_q : y_q;
	assign prod_x = 64'(mean_q) * 64'(cosv);
	assign prod_y = 64'(mean_q) * 64'(sinv);
	assign load_out = (state_q == S_OUT) && (!out_valid_q || !out_stall);
	assign q_pop = (state_q == S_IDLE) && q_valid;
	assign out_valid = out_valid_q;
	assign out_word = out_word_q;

	always_comb begin
		r1 = r0;
		if (r0 > $signed(odo_pkg::HALF_PI_Q24[27:0]))
			r1 = r0 - $signed(odo_pkg::PI_Q24[27:0]);
		else if (r0 < -$signed(odo_pkg::HALF_PI_Q24[27:0]))
			r1 = r0 + $signed(odo_pkg::PI_Q24[27:0]);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			out_valid_q <= 1'b0;
			x_acc_q <= '0;
			y_acc_q <= '0;
			heading_acc_q <= '0;
			right_acc_q <= '0;
			left_acc_q <= '0;
		end else begin
			if (out_valid_q && !out_stall && !load_out)
				out_valid_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (q_valid) begin
						dr_q <= $signed(q_dr);
						dl_q <= $signed(q_dl);
						if (q_req == odo_pkg::REQ_RESET) begin
							x_acc_q <= '0;
							y_acc_q <= '0;
							heading_acc_q <= '0;
							right_acc_q <= '0;
							left_acc_q <= '0;
							mean_q <= '0;
							state_q <= S_OUT;
						end else begin
							state_q <= S_MUL1;
						end
					end
				end
				S_MUL1: begin
					tr_q <= dr_ext * {32'd0, cfg.meters_per_tick};
					tl_q <= dl_ext * {32'd0, cfg.meters_per_tick};
					state_q <= S_MUL2;
				end
				S_MUL2: begin
					rd_q <= p_r[55:24];
					ld_q <= p_l[55:24];
					state_q <= S_HEAD;
				end
				S_HEAD: begin
					mean_q <= sum[32:1];
					right_acc_q <= right_acc_q + rd_q;
					left_acc_q <= left_acc_q + ld_q;
					heading_acc_q <= heading_new;
					red_q <= 34'($signed(heading_new)) + odo_pkg::TURNS_OFFSET;
					k_q <= 3'd5;
					state_q <= S_RED;
				end
				S_RED: begin
					// restoring reduction modulo two pi, one multiple per cycle
					if (red_q >= red_sub)
						red_q <= red_q - red_sub;
					k_q <= k_q - 3'd1;
					if (k_q == 3'd0)
						state_q <= S_FOLD;
				end
				S_FOLD: begin
					r_q <= r1;
					neg_q <= (r1 != r0);
					x_q <= odo_pkg::GAIN_Q30;
					y_q <= '0;
					it_q <= '0;
					state_q <= S_CORD;
				end
				S_CORD: begin
					if (!r_q[27]) begin
						x_q <= x_q - dx;
						y_q <= y_q + dy;
						r_q <= r_q - atn;
					end else begin
						x_q <= x_q + dx;
						y_q <= y_q - dy;
						r_q <= r_q + atn;
					end
					it_q <= it_q + 6'd1;
					if (it_q == LAST_STEP)
						state_q <= S_POS;
				end
				S_POS: begin
					px_q <= prod_x[61:30];
					py_q <= prod_y[61:30];
					state_q <= S_ACC;
				end
				S_ACC: begin
					x_acc_q <= x_acc_q + px_q;
					y_acc_q <= y_acc_q + py_q;
					state_q <= S_OUT;
				end
				S_OUT: begin
					if (load_out) begin
						out_valid_q <= 1'b1;
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			out_word_q.pos_x <= $signed(x_acc_q);
			out_word_q.pos_y <= $signed(y_acc_q);
			out_word_q.heading <= $signed(heading_acc_q);
			out_word_q.step_distance <= mean_q;
			out_word_q.right_travel <= $signed(right_acc_q);
			out_word_q.left_travel <= $signed(left_acc_q);
		end
	end

endmodule
`default_nettype wire

// ----- rtl/differential_drive_odometry_core.sv -----
// an update word passes the queue, then MUL1, MUL2, HEAD, RED, FOLD, CORD, POS, ACC and
// OUT; a pose reset word goes from the queue straight to OUT
// the back end takes a new word only after it has passed the last to the output register, its pace set by
// the iterative cordic and the six-step heading reduction; a two-word queue lets input run ahead
// reset: async active low, clears pose, travel, latched counts and restores register defaults
`default_nettype none
module differential_drive_odometry_core #(
	parameter int unsigned CORDIC_ITERATIONS = 24,
	parameter int unsigned ENCODER_WIDTH = 16
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic in_valid,
	output logic in_stall,
	input wire odo_pkg::in_word_t in_word,
	output logic out_valid,
	input wire logic out_stall,
	output odo_pkg::out_word_t out_word,
	input wire logic cfg_we,
	input wire logic [odo_pkg::CFG_IDX_W-1:0] cfg_index,
	input wire logic [odo_pkg::CFG_DATA_W-1:0] cfg_data
);

	odo_pkg::cfg_t cfg_q;
	logic q_valid, q_pop, q_req;
	logic [ENCODER_WIDTH-1:0] q_dr, q_dl;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.meters_per_tick <= 24'd0;
			cfg_q.right_ratio <= 18'd65536;
			cfg_q.left_ratio <= 18'd65536;
			cfg_q.inv_wheel_base <= 24'd65536;
		end else if (cfg_we) begin
			case (cfg_index)
				odo_pkg::CFG_METERS_PER_TICK: cfg_q.meters_per_tick <= cfg_data;
				odo_pkg::CFG_RIGHT_RATIO: cfg_q.right_ratio <= cfg_data[17:0];
				odo_pkg::CFG_LEFT_RATIO: cfg_q.left_ratio <= cfg_data[17:0];
				odo_pkg::CFG_INV_WHEEL_BASE: cfg_q.inv_wheel_base <= cfg_data;
				default: ;
			endcase
		end
	end

	odo_front #(.ENC_W(ENCODER_WIDTH)) u_front (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .in_word(in_word),
		.q_valid(q_valid), .q_pop(q_pop), .q_req(q_req), .q_dr(q_dr), .q_dl(q_dl)
	);

	odo_back #(.ENC_W(ENCODER_WIDTH), .ITER(CORDIC_ITERATIONS)) u_back (
		.clk(clk), .arst_n(arst_n), .cfg(cfg_q),
		.q_valid(q_valid), .q_pop(q_pop), .q_req(q_req), .q_dr(q_dr), .q_dl(q_dl),
		.out_valid(out_valid), .out_stall(out_stall), .out_word(out_word)
	);

endmodule
`default_nettype wire

// ----- rtl/odo_checker.sv -----
`default_nettype none
module odo_checker (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic in_valid,
	input wire logic in_stall,
	input wire logic out_valid,
	input wire logic out_stall,
	input wire odo_pkg::out_word_t out_word
);

	logic [2:0] pend_q;
	logic in_acc, out_acc;

	assign in_acc = in_valid && !in_stall;
	assign out_acc = out_valid && !out_stall;

	// words taken in but not yet delivered
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			pend_q <= 3'd0;
		else if (in_acc && !out_acc)
			pend_q <= pend_q + 3'd1;
		else if (out_acc && !in_acc)
			pend_q <= pend_q - 3'd1;
	end

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid)
		else $error("output word dropped while stalled");

	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> $stable(out_word))
		else $error("output word changed while stalled");

	a_no_invent: assert property (@(posedge clk) disable iff (!arst_n)
		out_acc |-> pend_q != 3'd0)
		else $error("output word without an input word");

	a_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		pend_q <= 3'd4)
		else $error("more words in flight than the queue and stages hold");

endmodule

bind differential_drive_odometry_core odo_checker u_odo_checker (
	.clk(clk), .arst_n(arst_n),
	.in_valid(in_valid), .in_stall(in_stall),
	.out_valid(out_valid), .out_stall(out_stall), .out_word(out_word)
);
`default_nettype wire

// ----- dv/tb_differential_drive_odometry_core.sv -----
`timescale 1ns / 100ps
`default_nettype none
module tb_differential_drive_odometry_core;

	localparam int CORDIC_N = 24;
	localparam int LAT = CORDIC_N + 20;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	odo_pkg::in_word_t in_word = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	odo_pkg::out_word_t out_word;
	logic cfg_we = 1'b0;
	logic [odo_pkg::CFG_IDX_W-1:0] cfg_index = '0;
	logic [odo_pkg::CFG_DATA_W-1:0] cfg_data = '0;

	differential_drive_odometry_core #(
		.CORDIC_ITERATIONS(CORDIC_N),
		.ENCODER_WIDTH(16)
	) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.in_word(in_word),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_word(out_word),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	odo_pkg::in_word_t pending_words[$];
	odo_pkg::out_word_t expected_poses[$];
	int errors = 0;

	// predictor state
	logic [23:0] mpt = 24'd0;
	logic [17:0] ratio_r = 18'd65536;
	logic [17:0] ratio_l = 18'd65536;
	logic [23:0] inv_base = 24'd65536;
	logic [15:0] r_last = '0, l_last = '0;
	logic [31:0] x_sum = '0, y_sum = '0, hdg_sum = '0, r_sum = '0, l_sum = '0;

	function automatic longint floor_shr(longint v, int s);
		return v >>> s;
	endfunction

	function automatic longint count_delta(logic [15:0] now, logic [15:0] last);
		logic [15:0] d;
		d = now - last;
		return longint'($signed(d));
	endfunction

	function automatic logic [31:0] tick_distance(longint delta, logic [17:0] ratio);
		logic [63:0] p;
		p = 64'(delta) * 64'(mpt) * 64'(ratio);
		return p[55:24];
	endfunction

	function automatic longint atan_entry(int i);
		case (i)
			0: return 13176795;
			1: return 7778716;
			2: return 4110060;
			3: return 2086331;
			4: return 1047214;
			5: return 524117;
			6: return 262123;
			7: return 131069;
			default: return (i <= 24) ? (longint'(1) << (24 - i)) : 0;
		endcase
	endfunction

	task automatic rotate_heading(input logic [31:0] ang, output longint c, output longint s);
		longint r, x, y, dx, dy;
		bit flip;
		r = longint'($signed(ang)) % 105414357;
		flip = 1'b0;
		x = 652032874;
		y = 0;
		if (r < 0) r += 105414357;
		if (r > 52707179) r -= 105414357;
		if (r > 26353589) begin
			r -= 52707179;
			flip = 1'b1;
		end else if (r < -26353589) begin
			r += 52707179;
			flip = 1'b1;
		end
		for (int i = 0; i < CORDIC_N && i < 32; i++) begin
			dx = floor_shr(y, i);
			dy = floor_shr(x, i);
			if (r >= 0) begin
				x -= dx;
				y += dy;
				r -= atan_entry(i);
			end else begin
				x += dx;
				y -= dy;
				r += atan_entry(i);
			end
		end
		c = flip ? -x : x;
		s = flip ? -y : y;
	endtask

	task automatic predict_pose(input odo_pkg::in_word_t w);
		odo_pkg::out_word_t o;
		logic [31:0] rd, ld, step;
		longint sum, diff, mean, c, s;
		logic [63:0] hp, px, py;
		step = '0;
		if (w.req_type == odo_pkg::REQ_RESET) begin
			x_sum = '0;
			y_sum = '0;
			hdg_sum = '0;
			r_sum = '0;
			l_sum = '0;
		end else begin
			rd = tick_distance(count_delta(w.right_count, r_last), ratio_r);
			ld = tick_distance(count_delta(w.left_count, l_last), ratio_l);
			sum = longint'($signed(rd)) + longint'($signed(ld));
			diff = longint'($signed(rd)) - longint'($signed(ld));
			mean = floor_shr(sum, 1);
			hp = 64'(diff) * 64'(inv_base);
			r_sum += rd;
			l_sum += ld;
			hdg_sum += hp[39:8];
			step = mean[31:0];
			rotate_heading(hdg_sum, c, s);
			px = floor_shr(mean * c, 30);
			py = floor_shr(mean * s, 30);
			x_sum += px[31:0];
			y_sum += py[31:0];
		end
		r_last = w.right_count;
		l_last = w.left_count;
		o.pos_x = x_sum;
		o.pos_y = y_sum;
		o.heading = hdg_sum;
		o.step_distance = step;
		o.right_travel = r_sum;
		o.left_travel = l_sum;
		expected_poses.push_back(o);
	endtask

	// driver: bursts and gaps
	int gap_left = 0, burst_left = 0;
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && !in_stall) begin
				predict_pose(in_word);
				if (burst_left > 0) burst_left <= burst_left - 1;
			end
			if (!in_valid || !in_stall) begin
				if (gap_left > 0) begin
					gap_left <= gap_left - 1;
					in_valid <= 1'b0;
				end else if (pending_words.size() > 0 &&
						(burst_left > 0 || !(in_valid && !in_stall))) begin
					in_word <= pending_words.pop_front();
					in_valid <= 1'b1;
					if (burst_left == 0) burst_left <= $urandom_range(1, 12);
				end else begin
					in_valid <= 1'b0;
					if (burst_left <= 1 && pending_words.size() > 0)
						gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 60);
				end
			end
		end
	end

	// monitor and receiver stall pattern
	int stall_phase = 0;
	always @(posedge clk) begin
		if (arst_n) begin
			stall_phase <= (stall_phase + 1) % 200;
			out_stall <= (stall_phase < 60) ? 1'b0 : ($urandom_range(0, 3) == 0);
			if (out_valid && !out_stall) begin
				if (expected_poses.size() == 0) begin
					$display("%0t unexpected word, expected none, actual %h", $time, out_word);
					errors++;
				end else begin
					automatic odo_pkg::out_word_t e = expected_poses.pop_front();
					if (e.pos_x !== out_word.pos_x ||
							e.pos_y !== out_word.pos_y ||
							e.heading !== out_word.heading ||
							e.step_distance !== out_word.step_distance ||
							e.right_travel !== out_word.right_travel ||
							e.left_travel !== out_word.left_travel) begin
						$display("%0t mismatch expected x=%0d y=%0d h=%0d s=%0d r=%0d l=%0d",
							$time, e.pos_x, e.pos_y, e.heading, e.step_distance,
							e.right_travel, e.left_travel);
						$display("%0t          actual x=%0d y=%0d h=%0d s=%0d r=%0d l=%0d",
							$time, out_word.pos_x, out_word.pos_y, out_word.heading,
							out_word.step_distance, out_word.right_travel, out_word.left_travel);
						errors++;
					end
				end
			end
		end
	end

	task automatic write_reg(input logic [odo_pkg::CFG_IDX_W-1:0] idx, input logic [23:0] val);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		case (idx)
			odo_pkg::CFG_METERS_PER_TICK: mpt = val;
			odo_pkg::CFG_RIGHT_RATIO: ratio_r = val[17:0];
			odo_pkg::CFG_LEFT_RATIO: ratio_l = val[17:0];
			odo_pkg::CFG_INV_WHEEL_BASE: inv_base = val;
			default: ;
		endcase
	endtask

	task automatic drain;
		while (pending_words.size() > 0 || in_valid || expected_poses.size() > 0)
			@(posedge clk);
		repeat (LAT) @(posedge clk);
	endtask

	function automatic odo_pkg::in_word_t make_word(logic t, logic [15:0] r, logic [15:0] l);
		odo_pkg::in_word_t w;
		w.req_type = t;
		w.right_count = r;
		w.left_count = l;
		return w;
	endfunction

	// random walk of encoder counts, occasional big jumps and pose resets
	logic [15:0] walk_r = '0, walk_l = '0;
	task automatic queue_random(int n, int span);
		for (int i = 0; i < n; i++) begin
			case ($urandom_range(0, 19))
				0: pending_words.push_back(make_word(odo_pkg::REQ_RESET,
					16'($urandom), 16'($urandom)));
				1, 2: pending_words.push_back(make_word(odo_pkg::REQ_UPDATE,
					16'($urandom), 16'($urandom)));
				default: begin
					walk_r += 16'($urandom_range(0, 2 * span) - span);
					walk_l += 16'($urandom_range(0, 2 * span) - span);
					pending_words.push_back(make_word(odo_pkg::REQ_UPDATE, walk_r, walk_l));
				end
			endcase
		end
	endtask

	initial begin
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;

		// directed, default registers: distances are zero
		pending_words.push_back(make_word(odo_pkg::REQ_UPDATE, 16'd100, 16'd50));
		pending_words.push_back(make_word(odo_pkg::REQ_RESET, 16'hFFFF, 16'h0000));
		drain();

		write_reg(odo_pkg::CFG_METERS_PER_TICK, 24'hFFFFFF);
		write_reg(odo_pkg::CFG_RIGHT_RATIO, 24'h3FFFF);
		write_reg(odo_pkg::CFG_LEFT_RATIO, 24'h0);
		write_reg(odo_pkg::CFG_INV_WHEEL_BASE, 24'hFFFFFF);
		// counter wrap, half range both ways, large product wrap
		pending_words.push_back(make_word(odo_pkg::REQ_UPDATE, 16'h0000, 16'h0001));
		pending_words.push_back(make_word(odo_pkg::REQ_UPDATE, 16'h7FFF, 16'h8000));
		pending_words.push_back(make_word(odo_pkg::REQ_UPDATE, 16'hFFFF, 16'hFFFF));
		pending_words.push_back(make_word(odo_pkg::REQ_UPDATE, 16'h7FFF, 16'h7FFE));
		pending_words.push_back(make_word(odo_pkg::REQ_UPDATE, 16'h8000, 16'h0000));
		pending_words.push_back(make_word(odo_pkg::REQ_RESET, 16'h1234, 16'hEDCB));
		pending_words.push_back(make_word(odo_pkg::REQ_UPDATE, 16'h1000, 16'hF000));
		drain();

		write_reg(odo_pkg::CFG_METERS_PER_TICK, 24'd16777);
		write_reg(odo_pkg::CFG_RIGHT_RATIO, 24'd65536);
		write_reg(odo_pkg::CFG_LEFT_RATIO, 24'd65536);
		write_reg(odo_pkg::CFG_INV_WHEEL_BASE, 24'd200000);
		// spin in place so heading passes every quadrant and wraps
		pending_words.push_back(make_word(odo_pkg::REQ_RESET, 16'd0, 16'd0));
		for (int i = 1; i <= 10; i++)
			pending_words.push_back(make_word(odo_pkg::REQ_UPDATE,
				16'(i * 3000), 16'(-i * 2500)));
		drain();

		// random phases over several register settings
		for (int ph = 0; ph < 6; ph++) begin
			write_reg(odo_pkg::CFG_METERS_PER_TICK,
				(ph == 5) ? 24'hFFFFFF : 24'($urandom_range(0, 24'hFFFFFF)));
			write_reg(odo_pkg::CFG_RIGHT_RATIO,
				(ph == 4) ? 24'h3FFFF : 24'($urandom_range(0, 18'h3FFFF)));
			write_reg(odo_pkg::CFG_LEFT_RATIO,
				(ph == 3) ? 24'h0 : 24'($urandom_range(0, 18'h3FFFF)));
			write_reg(odo_pkg::CFG_INV_WHEEL_BASE, 24'($urandom));
			queue_random(90, (ph < 3) ? 40 : 32767);
			drain();
		end
		if (errors == 0) $display("PASS differential_drive_odometry_core");
		else $display("FAIL differential_drive_odometry_core");
		$finish;
	end

	initial begin
		#20ms;
		$display("FAIL differential_drive_odometry_core");
		$finish;
	end

endmodule
`default_nettype wire
